@@ sv/quad_float_binary_scale_macros.svh @@
// Assertion macros for the checker file
`ifndef QUAD_FLOAT_BINARY_SCALE_MACROS_SVH
`define QUAD_FLOAT_BINARY_SCALE_MACROS_SVH
// clocked implication with reset disable
`define QFBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication with reset disable
`define QFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/qfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// qfbs_pkg
// Types and constants for the binary128 power-of-two scaler.
// ----------------------------------------------------------------------------
package qfbs_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned EXP_W      = 15;
    localparam int unsigned FRAC_W     = 112;
    localparam int unsigned SIG_W      = 113;
    localparam int unsigned E_W        = 18;   // signed working exponent
    localparam logic [EXP_W-1:0] EXP_MAX = 15'h7FFF;
    localparam int signed SCALE_LIMIT  = 40000;
    localparam int unsigned FAR_SHIFT  = 120;

    typedef struct packed {
        logic [WORD_W-1:0] value_high;
        logic [WORD_W-1:0] value_low;
        logic signed [WORD_W-1:0] scale_count;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] result_high;
        logic [WORD_W-1:0] result_low;
        logic              overflow_flag;
        logic              underflow_flag;
    } t_out_beat;

    // leading zero count of a 113-bit significand (value 0..113)
    function automatic logic [6:0] lzc113(input logic [SIG_W-1:0] x);
        logic [6:0] n;
        logic       found;
        n = 7'(SIG_W);
        found = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!found && x[i]) begin
                n = 7'(SIG_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

@@ sv/qfbs_if.sv @@
// ----------------------------------------------------------------------------
// qfbs_in_if / qfbs_out_if
// Valid/ready channels carrying operand and result beats.
// ----------------------------------------------------------------------------
interface qfbs_in_if;
    logic                valid;
    logic                ready;
    qfbs_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qfbs_out_if;
    logic                valid;
    logic                ready;
    qfbs_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/qfbs_core.sv @@
// ----------------------------------------------------------------------------
// qfbs_core
// Combinational scale of one registered operand: pass specials, normalize,
// add exponent, pack or overflow to infinity, or denormalize, round to nearest even.
// ----------------------------------------------------------------------------
module qfbs_core (
    input  qfbs_pkg::t_in_beat  i_beat,
    output qfbs_pkg::t_out_beat o_beat
);
    logic                      sign;
    logic [qfbs_pkg::EXP_W-1:0] bexp;
    logic [qfbs_pkg::FRAC_W-1:0] frac;
    logic [qfbs_pkg::SIG_W-1:0] sig_raw;
    logic [qfbs_pkg::SIG_W-1:0] sig_n;
    logic [6:0]                lz;
    logic signed [qfbs_pkg::E_W-1:0] k_sat;
    logic signed [qfbs_pkg::E_W-1:0] e_base;
    logic signed [qfbs_pkg::E_W-1:0] e_sum;
    logic signed [qfbs_pkg::E_W-1:0] d;
    logic [6:0]                n_sh;
    logic [qfbs_pkg::SIG_W:0]  ext;     // significand with round bit below
    logic [qfbs_pkg::SIG_W:0]  shifted;
    logic [qfbs_pkg::SIG_W:0]  mask;
    logic                      sticky;
    logic                      rbit;
    logic [qfbs_pkg::SIG_W-1:0] q;
    logic [qfbs_pkg::SIG_W-1:0] q_rnd;
    logic                      special;
    logic signed [qfbs_pkg::WORD_W-1:0] sc;

    always_comb begin
        sign    = i_beat.value_high[63];
        bexp    = i_beat.value_high[62:48];
        frac    = {i_beat.value_high[47:0], i_beat.value_low};
        sig_raw = {(bexp != '0), frac};
        lz      = qfbs_pkg::lzc113(sig_raw);
        special = (bexp == qfbs_pkg::EXP_MAX) || (bexp == '0 && frac == '0);
        sc      = i_beat.scale_count;
        if (sc > 64'(qfbs_pkg::SCALE_LIMIT)) begin
            k_sat = qfbs_pkg::E_W'(qfbs_pkg::SCALE_LIMIT);
        end else if (sc < -64'sd40000) begin
            k_sat = -qfbs_pkg::E_W'(qfbs_pkg::SCALE_LIMIT);
        end else begin
            k_sat = sc[qfbs_pkg::E_W-1:0];
        end
        if (bexp == '0) begin
            sig_n  = sig_raw << lz;
            e_base = qfbs_pkg::E_W'(1) - qfbs_pkg::E_W'(lz);
        end else begin
            sig_n  = sig_raw;
            e_base = qfbs_pkg::E_W'(bexp);
        end
        e_sum = e_base + k_sat;
        d     = qfbs_pkg::E_W'(1) - e_sum;
        if (d > $signed(qfbs_pkg::E_W'(qfbs_pkg::FAR_SHIFT)) || d < 0) begin
            n_sh = 7'(qfbs_pkg::FAR_SHIFT);
        end else begin
            n_sh = d[6:0];
        end
        ext     = {sig_n, 1'b0};
        shifted = ext >> n_sh;
        mask    = ~({(qfbs_pkg::SIG_W+1){1'b1}} << n_sh);
        sticky  = |(ext & mask);
        rbit    = shifted[0];
        q       = shifted[qfbs_pkg::SIG_W:1];
        q_rnd   = q + qfbs_pkg::SIG_W'(rbit && (sticky || q[0]));

        o_beat = '0;
        if (special) begin
            o_beat.result_high = i_beat.value_high;
            o_beat.result_low  = i_beat.value_low;
        end else if (e_sum >= $signed({3'b000, qfbs_pkg::EXP_MAX})) begin
            o_beat.result_high   = {sign, qfbs_pkg::EXP_MAX, 48'h0};
            o_beat.overflow_flag = 1'b1;
        end else if (e_sum >= qfbs_pkg::E_W'(1)) begin
            o_beat.result_high = {sign, e_sum[qfbs_pkg::EXP_W-1:0], sig_n[111:64]};
            o_beat.result_low  = sig_n[63:0];
        end else begin
            o_beat.result_high    = {sign, 14'h0, q_rnd[112:64]};
            o_beat.result_low     = q_rnd[63:0];
            o_beat.underflow_flag = 1'b1;
        end
    end
endmodule

@@ sv/quad_float_binary_scale.sv @@
// Input register (r_s1) and result register (r_s2) lie between input and result beat.
// Throughput: one beat per cycle while the output is not stalled; the single-pass
// scale path sets the clock. The result register is a skid-free stage: input
// accepts while r_s1 is empty or the output is empty or being drained this cycle.
// Reset: synchronous active-low; clears the valid bits only.
// ----------------------------------------------------------------------------
// quad_float_binary_scale
// Binary128 scale by a signed power of two, round to nearest even.
// ----------------------------------------------------------------------------
module quad_float_binary_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qfbs_in_if.sink         i_in,
    qfbs_out_if.source      o_out
);
    logic                r_s1_vld;
    qfbs_pkg::t_in_beat  r_s1;
    logic                r_s2_vld;
    qfbs_pkg::t_out_beat r_s2;
    qfbs_pkg::t_out_beat n_s2;
    logic                s2_free;
    logic                s1_free;

    assign s2_free    = !r_s2_vld || o_out.ready;
    assign s1_free    = !r_s1_vld || s2_free;
    assign i_in.ready = s1_free;
    assign o_out.valid = r_s2_vld;
    assign o_out.data  = r_s2;

    qfbs_core u_core (
        .i_beat (r_s1),
        .o_beat (n_s2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1 <= i_in.data;
        end
        if (s2_free && r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end
endmodule

@@ sv/qfbs_checker.sv @@
// ----------------------------------------------------------------------------
// qfbs_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_float_binary_scale_macros.svh"

module qfbs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input qfbs_pkg::t_out_beat out_data
);
    `QFBS_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, out_valid, !(out_data.overflow_flag && out_data.underflow_flag), "both flags set")
    `QFBS_ASSERT_IMP(a_ovf_inf, i_clk, i_rst_n, out_valid && out_data.overflow_flag, out_data.result_high[62:48] == qfbs_pkg::EXP_MAX && out_data.result_low == '0, "overflow without infinity")
    `QFBS_ASSERT_IMP(a_ready_drain, i_clk, i_rst_n, out_ready, in_ready, "input blocked while output drains")
    `QFBS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
endmodule

bind quad_float_binary_scale qfbs_checker u_qfbs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.data)
);
